// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and tables for the priority target selector.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int PRIORITY_SLOTS_DEF = 8;
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int MAX_STEPS          = 24;

    localparam logic [2:0] REG_MIN_CONF  = 3'd0;
    localparam logic [2:0] REG_MAX_DIST  = 3'd1;
    localparam logic [2:0] REG_REF_YAW   = 3'd2;
    localparam logic [2:0] REG_MAX_DEV   = 3'd3;
    localparam logic [2:0] REG_PRIO_IDS  = 3'd4;
    localparam logic [2:0] REG_PRIO_CNT  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SQRT,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [3:0]  id;
        logic [15:0] conf;
        logic [15:0] dev;
        logic [16:0] dist_mm;
    } record_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/priority_target_selector_top.sv =====
// ----------------------------------------------------------------------------
// priority_target_selector_top
// Frame-wise target selection by priority list and least yaw deviation.
// ----------------------------------------------------------------------------
// A track sums the squares of x, y and z, then runs the square root with the
// CORDIC alongside, then a decide state; a new track is taken only once the
// decide state has returned to idle. The result holds until taken; a waiting
// result stalls only the decide state of the next frame's last track.
// Synchronous active-low reset restores the configuration and clears winners.
module priority_target_selector_top import pts_pkg::*; #(
    parameter int PRIORITY_SLOTS = PRIORITY_SLOTS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // track_id[3:0], confidence[19:4], pos_x[36:20], pos_y[53:37], pos_z[70:54]
    input  logic [71:0] s_tdata,
    // visible
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], chosen_id[4:1], chosen_confidence[20:5], yaw_offset[36:21],
    // distance[53:37]
    output logic [55:0] m_tdata
);
    localparam int SLOTS = (PRIORITY_SLOTS > 8) ? 8 : PRIORITY_SLOTS;

    logic [15:0] min_conf_reg, ref_yaw_reg, max_dev_reg;
    logic [16:0] max_dist_reg;
    logic [31:0] prio_ids_reg;
    logic [3:0]  prio_cnt_reg;

    state_t state_reg, state_next;
    logic [3:0]  id_reg;
    logic        vis_reg, last_reg;
    logic [15:0] conf_reg;
    logic signed [16:0] x_reg, y_reg, z_reg;
    logic [35:0] sq_reg;
    logic [15:0] yaw_reg;
    logic        cdone_reg, cdone_next, sdone_reg, sdone_next;

    logic        pv_reg, pv_next, nv_reg, nv_next;
    logic [2:0]  prank_reg, prank_next;
    record_t     prec_reg, prec_next, nrec_reg, nrec_next;
    logic [55:0] out_reg, out_next;
    logic        mval_reg, mval_next;

    logic        accept, c_done, s_done, sq_start, commit;
    logic [15:0] yaw_w, d, dev;
    logic [16:0] root;
    logic [33:0] sx, sy, sz;
    logic [35:0] sq;
    logic [33:0] lim;
    logic        elig, hit;
    logic [2:0]  hrank;
    logic [3:0]  cnt;
    record_t     rec, res;

    logic [1:0] sqp_reg, sqp_next;
    logic signed [16:0] sqop;
    logic signed [33:0] sqe;
    logic [33:0] prod;
    logic [35:0] acc_reg, acc_next;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign sq_start = (state_reg == ST_CORDIC) && (sqp_reg == 2'd3);
    assign commit = (state_reg == ST_DECIDE) && !(last_reg && mval_reg && !m_tready);

    pts_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .x_in(s_tdata[36:20]), .y_in(s_tdata[53:37]),
        .done(c_done), .yaw(yaw_w)
    );

    pts_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .value(sq), .done(s_done), .root(root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_conf_reg <= '0; max_dist_reg <= 17'h1FFFF; ref_yaw_reg <= '0;
            max_dev_reg <= 16'd32768; prio_ids_reg <= '0; prio_cnt_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MIN_CONF: min_conf_reg <= cfg_wdata[15:0];
                REG_MAX_DIST: max_dist_reg <= cfg_wdata[16:0];
                REG_REF_YAW:  ref_yaw_reg  <= cfg_wdata[15:0];
                REG_MAX_DEV:  max_dev_reg  <= cfg_wdata[15:0];
                REG_PRIO_IDS: prio_ids_reg <= cfg_wdata;
                REG_PRIO_CNT: prio_cnt_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            id_reg <= s_tdata[3:0]; conf_reg <= s_tdata[19:4];
            x_reg <= s_tdata[36:20]; y_reg <= s_tdata[53:37];
            z_reg <= s_tdata[70:54]; vis_reg <= s_tuser; last_reg <= s_tlast;
        end
        if (state_reg == ST_CORDIC) sq_reg <= sq;
        if (c_done) yaw_reg <= yaw_w;
    end

    // one squaring per cycle of the CORDIC state, reusing the product slot
    always_comb begin
        unique case (sqp_reg)
            2'd0: sqop = x_reg;
            2'd1: sqop = y_reg;
            default: sqop = z_reg;
        endcase
        sqe = 34'(sqop);
        prod = sqe * sqe;
        sx = prod; sy = '0; sz = '0;
        sq = acc_reg;
        acc_next = acc_reg;
        sqp_next = sqp_reg;
        if (accept) begin
            acc_next = '0; sqp_next = 2'd0;
        end else if (state_reg == ST_CORDIC && sqp_reg != 2'd3) begin
            acc_next = acc_reg + 36'(sx) + 36'(sy) + 36'(sz);
            sqp_next = sqp_reg + 2'd1;
        end
    end

    always_comb begin
        state_next = state_reg;
        cdone_next = cdone_reg;
        sdone_next = sdone_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) begin
                           state_next = ST_CORDIC; cdone_next = 1'b0;
                           sdone_next = 1'b0;
                       end
            ST_CORDIC: if (sqp_reg == 2'd3) state_next = ST_SQRT;
            ST_SQRT:   begin
                           if (c_done) cdone_next = 1'b1;
                           if (s_done) sdone_next = 1'b1;
                           if ((c_done || cdone_reg) && (s_done || sdone_reg))
                               state_next = ST_DECIDE;
                       end
            ST_DECIDE: if (commit) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        res = '0;
        d = yaw_reg - ref_yaw_reg;
        dev = (d > 16'd32768) ? 16'(17'd65536 - 17'(d)) : d;
        lim = 34'(max_dist_reg) * 34'(max_dist_reg);
        elig = vis_reg && conf_reg >= min_conf_reg && sq_reg <= 36'(lim) &&
               dev <= max_dev_reg;
        rec = '{id: id_reg, conf: conf_reg, dev: dev, dist_mm: root};
        cnt = (prio_cnt_reg > 4'(SLOTS)) ? 4'(SLOTS) : prio_cnt_reg;
        hit = 1'b0; hrank = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (4'(s) < cnt && prio_ids_reg[4*s +: 4] == id_reg) begin
                hit = 1'b1; hrank = 3'(s);
            end
        end
        pv_next = pv_reg; prank_next = prank_reg; prec_next = prec_reg;
        nv_next = nv_reg; nrec_next = nrec_reg;
        out_next = out_reg; mval_next = mval_reg;
        if (m_tvalid && m_tready) mval_next = 1'b0;
        if (commit) begin
            if (elig && hit && (!pv_reg || hrank < prank_reg)) begin
                pv_next = 1'b1; prank_next = hrank; prec_next = rec;
            end
            if (elig && (!nv_reg || dev < nrec_reg.dev)) begin
                nv_next = 1'b1; nrec_next = rec;
            end
            if (last_reg) begin
                res = pv_next ? prec_next : (nv_next ? nrec_next : '0);
                out_next = {2'b00, res.dist_mm, res.dev, res.conf, res.id,
                            pv_next || nv_next};
                mval_next = 1'b1;
                pv_next = 1'b0; nv_next = 1'b0; prank_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; pv_reg <= 1'b0; nv_reg <= 1'b0;
            prank_reg <= '0; mval_reg <= 1'b0; cdone_reg <= 1'b0;
            sdone_reg <= 1'b0; sqp_reg <= '0;
        end else begin
            state_reg <= state_next; pv_reg <= pv_next; nv_reg <= nv_next;
            prank_reg <= prank_next; mval_reg <= mval_next;
            cdone_reg <= cdone_next; sdone_reg <= sdone_next; sqp_reg <= sqp_next;
        end
        prec_reg <= prec_next; nrec_reg <= nrec_next;
        out_reg <= out_next; acc_reg <= acc_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = out_reg;
endmodule

// ===== rtl/pts_cordic.sv =====
// ----------------------------------------------------------------------------
// pts_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module pts_cordic import pts_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic signed [16:0] x_in,
    input  logic signed [16:0] y_in,
    output logic        done,
    output logic [15:0] yaw
);
    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] z_reg, z_next;
    logic [4:0]  i_reg, i_next;
    logic        run_reg, run_next, zero_reg, zero_next, done_reg, done_next;
    logic signed [31:0] xs, ys, sx, sy;
    logic [31:0] zr;

    always_comb begin
        xs = 32'(x_in) <<< 12;
        ys = 32'(y_in) <<< 12;
        sx = x_reg >>> i_reg;
        sy = y_reg >>> i_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; run_next = run_reg; zero_next = zero_reg;
        done_next = 1'b0;
        if (start) begin
            zero_next = (x_in == 17'sd0) && (y_in == 17'sd0);
            run_next  = 1'b1;
            i_next    = 5'd0;
            if (x_in < 0) begin
                x_next = -xs; y_next = -ys; z_next = 32'h8000_0000;
            end else begin
                x_next = xs; y_next = ys; z_next = 32'd0;
            end
        end else if (run_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + atan_lut(i_reg);
            end else begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - atan_lut(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(STEPS - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
            done_reg <= done_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        i_reg <= i_next; zero_reg <= zero_next;
    end

    assign zr   = z_reg + 32'h0000_8000;
    assign done = done_reg;
    assign yaw  = zero_reg ? 16'd0 : zr[31:16];
endmodule

// ===== rtl/pts_sqrt.sv =====
// ----------------------------------------------------------------------------
// pts_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pts_sqrt import pts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [35:0] value,
    output logic        done,
    output logic [16:0] root
);
    logic [35:0] v_reg, v_next, r_reg, r_next, b_reg, b_next;
    logic        run_reg, run_next, done_reg, done_next;
    logic [35:0] t;

    always_comb begin
        t = r_reg + b_reg;
        v_next = v_reg; r_next = r_reg; b_next = b_reg;
        run_next = run_reg; done_next = 1'b0;
        if (start) begin
            v_next = value; r_next = '0;
            b_next = 36'h4_0000_0000;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (v_reg >= t) begin
                v_next = v_reg - t;
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            if (b_reg == 36'd1) begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
            done_reg <= done_next;
        end
        v_reg <= v_next; r_reg <= r_next; b_reg <= b_next;
    end

    assign done = done_reg;
    assign root = (r_reg[35:17] != '0) ? 17'h1FFFF : r_reg[16:0];
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the priority target selector frame by frame: random and directed
// tracks are driven in, a scoreboard predicts each frame's chosen target and
// compares it with the master-side transaction.
// ----------------------------------------------------------------------------
module tb import pts_pkg::*; ;

    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic        found;
        logic [3:0]  id;
        logic [15:0] conf;
        logic [15:0] dev;
        logic [16:0] dist_mm;
    } target_t;

    class target_board;
        logic [15:0] min_conf;
        logic [16:0] max_dist;
        logic [15:0] ref_yaw;
        logic [15:0] max_dev;
        logic [31:0] prio_ids;
        logic [3:0]  prio_cnt;
        bit          have_prio, have_near;
        int          best_slot;
        target_t     prio_pick, near_pick;
        target_t     pending[$];
        int          errors, frames;

        function new();
            min_conf = 0; max_dist = 17'h1FFFF; ref_yaw = 0; max_dev = 16'd32768;
            prio_ids = 0; prio_cnt = 0;
            have_prio = 0; have_near = 0; best_slot = 0;
            errors = 0; frames = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_MIN_CONF: min_conf = v[15:0];
                REG_MAX_DIST: max_dist = v[16:0];
                REG_REF_YAW:  ref_yaw  = v[15:0];
                REG_MAX_DEV:  max_dev  = v[15:0];
                REG_PRIO_IDS: prio_ids = v;
                REG_PRIO_CNT: prio_cnt = v[3:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] atan_tab(int i);
            logic [31:0] t[24] = '{536870912, 316933406, 167458907, 85004756,
                42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
                652, 326, 163, 81};
            return t[i];
        endfunction

        function logic [15:0] heading(longint x, longint y);
            logic [31:0] z;
            longint dx, dy;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 4096; y = y * 4096;
            if (x < 0) begin
                x = -x; y = -y; z = 32'h8000_0000;
            end
            for (int i = 0; i < ((CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF); i++) begin
                dx = y >>> i; dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_tab(i);
                end else begin
                    x -= dx; y += dy; z -= atan_tab(i);
                end
            end
            z = z + 32'h8000;
            return z[31:16];
        endfunction

        function longint root(longint v);
            longint r, b;
            r = 0; b = 64'd1 << 40;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_track(logic [3:0] id, logic vis, logic [15:0] conf,
                                 logic signed [16:0] px, logic signed [16:0] py,
                                 logic signed [16:0] pz, logic last);
            longint x, y, z, sq, dst;
            logic [15:0] d;
            int cnt;
            target_t rec, res;
            x = px; y = py; z = pz;
            sq = x * x + y * y + z * z;
            d = heading(x, y) - ref_yaw;
            if (d > 16'd32768) d = 16'd0 - d;
            dst = root(sq);
            if (dst > 131071) dst = 131071;
            if (vis && conf >= min_conf && sq <= longint'(max_dist) * max_dist
                && d <= max_dev) begin
                rec = '{1'b1, id, conf, d, dst[16:0]};
                cnt = (prio_cnt > 8) ? 8 : prio_cnt;
                for (int s = 0; s < cnt; s++)
                    if (prio_ids[4*s +: 4] == id) begin
                        if (!have_prio || s < best_slot) begin
                            have_prio = 1; best_slot = s; prio_pick = rec;
                        end
                        break;
                    end
                if (!have_near || d < near_pick.dev) begin
                    have_near = 1; near_pick = rec;
                end
            end
            if (last) begin
                res = have_prio ? prio_pick : (have_near ? near_pick : '0);
                pending = {pending, res};
                have_prio = 0; have_near = 0; best_slot = 0;
            end
        endfunction

        function void check(logic [55:0] data);
            target_t got, exp;
            got = '{data[0], data[4:1], data[20:5], data[36:21], data[53:37]};
            frames++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", data);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp f%0d id%0d c%0d dv%0d ds%0d got f%0d id%0d c%0d dv%0d ds%0d",
                        exp.found, exp.id, exp.conf, exp.dev, exp.dist_mm,
                        got.found, got.id, got.conf, got.dev, got.dist_mm);
            end
        endfunction
    endclass

    logic        aclk = 0, aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_tvalid = 0, s_tuser = 0, s_tlast = 0, m_tready = 0;
    logic [71:0] s_tdata = 0;
    logic        s_tready, m_tvalid;
    logic [55:0] m_tdata;
    target_board sb = new();
    int          idle_cycles = 0, tracks = 0;
    bit          drain = 0;

    priority_target_selector_top uut (.*);

    initial forever #10 aclk = ~aclk;

    function int gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("FAIL priority_target_selector_top");
            $finish;
        end
    end

    initial begin : sink
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            g = drain ? 0 : gap();
            if ($urandom_range(0, 3) == 0) g = 0;
            if (g > 0) begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk iff m_tvalid);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send_track(logic [3:0] id, logic vis, logic [15:0] conf,
                              logic [16:0] x, logic [16:0] y, logic [16:0] z,
                              logic last, bit hold);
        int g;
        g = hold ? 0 : gap();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {1'b0, z, y, x, conf, id};
        s_tuser <= vis; s_tlast <= last;
        @(posedge aclk iff s_tready);
        sb.note_track(id, vis, conf, x, y, z, last);
        tracks++;
    endtask

    function logic [16:0] rnd_pos();
        case ($urandom_range(0, 5))
            0: return 17'h10000;
            1: return 17'h0FFFF;
            2: return 17'h00000;
            3: return 17'($signed($urandom_range(0, 4000)) - 2000);
            default: return 17'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        int n;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++)
            send_track(4'($urandom_range(0, 15)), $urandom_range(0, 5) != 0,
                ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom), rnd_pos(),
                rnd_pos(), rnd_pos(), k == n - 1 || $urandom_range(0, 30) == 0,
                $urandom_range(0, 2) == 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: defaults, origin, extremes, empty frame
        send_track(4'd0, 1'b0, 16'd0, 17'd0, 17'd0, 17'd0, 1'b1, 0);
        send_track(4'd15, 1'b1, 16'hFFFF, 17'd0, 17'd0, 17'd0, 1'b1, 0);
        send_track(4'd3, 1'b1, 16'd100, 17'h10000, 17'h10000, 17'h10000, 1'b0, 0);
        send_track(4'd5, 1'b1, 16'd200, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 1'b1, 1);
        send_track(4'd1, 1'b1, 16'd1, 17'h10000, 17'd0, 17'd5, 1'b0, 0);
        send_track(4'd2, 1'b1, 16'd2, 17'd0, 17'h1FFFF, 17'd5, 1'b1, 0);
        wait_idle();
        // duplicates and oversize count
        write_reg(REG_PRIO_IDS, 32'h7755_3A92);
        write_reg(REG_PRIO_CNT, 32'd15);
        write_reg(REG_MIN_CONF, 32'd1000);
        write_reg(REG_MAX_DIST, 32'd50000);
        write_reg(REG_REF_YAW, 32'd16384);
        write_reg(REG_MAX_DEV, 32'd8000);
        send_track(4'd7, 1'b1, 16'd5000, 17'd10, 17'd900, 17'd0, 1'b0, 0);
        send_track(4'd9, 1'b1, 16'd5000, 17'd20, 17'd800, 17'd0, 1'b0, 0);
        send_track(4'd2, 1'b1, 16'd999, 17'd0, 17'd800, 17'd0, 1'b0, 0);
        send_track(4'd4, 1'b1, 16'd6000, 17'd0, 17'd700, 17'd0, 1'b1, 0);
        send_track(4'd4, 1'b1, 16'd6000, 17'd0, 17'd700, 17'd0, 1'b0, 0);
        send_track(4'd6, 1'b1, 16'd6000, 17'd0, 17'd700, 17'd0, 1'b1, 0);
        wait_idle();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_MIN_CONF, 0); write_reg(REG_MAX_DIST, 32'h1FFFF);
                    write_reg(REG_MAX_DEV, 32'd32768); write_reg(REG_REF_YAW, 0);
                end
                1: begin
                    write_reg(REG_MIN_CONF, 32'hFFFF); write_reg(REG_MAX_DIST, 0);
                    write_reg(REG_MAX_DEV, 0);
                end
                2: write_reg(REG_NONE, $urandom);
                default: begin
                    write_reg(REG_MIN_CONF, $urandom_range(0, 40000));
                    write_reg(REG_MAX_DIST, $urandom_range(1000, 131071));
                    write_reg(REG_REF_YAW, $urandom_range(0, 65535));
                    write_reg(REG_MAX_DEV, $urandom_range(0, 32768));
                end
            endcase
            write_reg(REG_PRIO_IDS, $urandom);
            write_reg(REG_PRIO_CNT, $urandom_range(0, 15));
            repeat (70) random_frame();
            wait_idle();
        end
        drain = 1;
        wait_idle();
        $display("Run drove %0d tracks, %0d frame results checked.", tracks, sb.frames);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS priority_target_selector_top");
        else
            $display("FAIL priority_target_selector_top");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/pts_pkg.sv
rtl/pts_cordic.sv
rtl/pts_sqrt.sv
rtl/priority_target_selector_top.sv
tb/sv/tb.sv
